// ===== src/port_allow_deny_filter_core_macros.svh =====
// Assertion macros for the port allow/deny filter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PORT_ALLOW_DENY_FILTER_CORE_MACROS_SVH
`define PORT_ALLOW_DENY_FILTER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define PAFILT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PAFILT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pafilt_pkg.sv =====
// Shared constants and types of the port allow/deny filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pafilt_pkg;

  // Block dimensions
  localparam int PROTO_COUNT = 2;
  localparam int PORT_BITS   = 16;
  localparam int PORT_FIELD_W = 16;
  localparam int CNT_W       = 17;

  // Bitmap row layout: one row holds 2^LANE_BITS ports, two bits each {deny, allow}
  localparam int LANE_BITS      = 5;
  localparam int ROW_W          = 2 << LANE_BITS;
  localparam int BIT_POS_W      = LANE_BITS + 1;
  localparam int ROWS_PER_PROTO = 1 << (PORT_BITS - LANE_BITS);
  localparam int RAM_DEPTH      = PROTO_COUNT * ROWS_PER_PROTO;
  localparam int PROTO_W        = (PROTO_COUNT > 1) ? $clog2(PROTO_COUNT) : 1;
  localparam int ROW_ADDR_W     = PROTO_W + PORT_BITS - LANE_BITS;

  // Set select codes
  localparam logic SEL_ALLOW = 1'b0;
  localparam logic SEL_DENY  = 1'b1;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_CHECK = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_DEL   = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Member count update request
  typedef struct packed {
    logic               inc;
    logic               dec;
    logic [PROTO_W-1:0] proto;
    logic               sel;
  } cnt_upd_t;

  // Member counts of one protocol
  typedef struct packed {
    logic [CNT_W-1:0] deny_cnt;
    logic [CNT_W-1:0] allow_cnt;
  } cnt_pair_t;

endpackage

// ===== src/pafilt_bitmap_ram.sv =====
// Membership bitmap memory: one write port, one registered read port.
// Depends on pafilt_pkg for the row width and depth.
`timescale 1ns / 1ps
module pafilt_bitmap_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [pafilt_pkg::ROW_ADDR_W-1:0] waddr,
  input  logic [pafilt_pkg::ROW_W-1:0]      wdata,
  input  logic                             re,
  input  logic [pafilt_pkg::ROW_ADDR_W-1:0] raddr,
  output logic [pafilt_pkg::ROW_W-1:0]      rdata
);
  import pafilt_pkg::*;

  logic [ROW_W-1:0] mem [RAM_DEPTH];
  logic [ROW_W-1:0] rdata_r;

  // Write a whole row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read a row, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pafilt_set_counts.sv =====
// Member counts of every (protocol, set) pair, cleared at reset.
// Depends on pafilt_pkg for the count width and update request type.
`timescale 1ns / 1ps
module pafilt_set_counts (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pafilt_pkg::PROTO_W-1:0] rd_proto,
  output pafilt_pkg::cnt_pair_t          rd_cnt,
  input  pafilt_pkg::cnt_upd_t           upd
);
  import pafilt_pkg::*;

  logic [CNT_W-1:0] cnt_r [PROTO_COUNT][2];

  // Step the selected count up on an add, down on a delete
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PROTO_COUNT; p++) begin
        for (int s = 0; s < 2; s++) begin
          cnt_r[p][s] <= '0;
        end
      end
    end else if (upd.inc) begin
      cnt_r[upd.proto][upd.sel] <= cnt_r[upd.proto][upd.sel] + 1'b1;
    end else if (upd.dec) begin
      cnt_r[upd.proto][upd.sel] <= cnt_r[upd.proto][upd.sel] - 1'b1;
    end
  end

  // Both counts of the requested protocol
  assign rd_cnt.allow_cnt = cnt_r[rd_proto][SEL_ALLOW];
  assign rd_cnt.deny_cnt  = cnt_r[rd_proto][SEL_DENY];

endmodule

// ===== src/port_allow_deny_filter_core.sv =====
// Port allow/deny filter top level: request control, bitmap read-modify-write.
// Result: registered in the output slot when the held request finishes in ST_RMW; held back while out_tready is low.
// Requests: one at a time; in_tready stays low in ST_RMW until the held request finishes its bitmap read-modify-write.
// Reset: synchronous; counts clear at once, then a clearing pass writes all
// 4096 bitmap rows with in_tready low.
`timescale 1ns / 1ps
module port_allow_deny_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] port
  input  logic [3:0]  in_tuser,   // [1:0] kind, [2] protocol, [3] list_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] allowed, [7:1] zero
  output logic [0:0]  out_tuser   // [0] was_present
);
  import pafilt_pkg::*;

  `include "port_allow_deny_filter_core_macros.svh"

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RMW   = 3'b100
  } state_t;

  state_t st_r, st_nxt;

  logic [ROW_ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  kind_t                 kind_r;
  logic [PROTO_W-1:0]    proto_r;
  logic                  pvalid_r;
  logic                  sel_r;
  logic [LANE_BITS-1:0]  lane_r;
  logic [ROW_ADDR_W-1:0] row_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_allowed_r;
  logic                  out_present_r;

  logic                  in_acc;
  kind_t                 in_kind;
  logic [PROTO_W-1:0]    in_proto;
  logic                  in_pvalid;
  logic [PORT_BITS-1:0]  in_port;
  logic [ROW_ADDR_W-1:0] in_row;

  logic                  ram_we;
  logic [ROW_ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;

  cnt_pair_t             cnt;
  cnt_upd_t              upd;

  logic                  rmw_go;
  logic [BIT_POS_W-1:0]  a_pos, d_pos, s_pos;
  logic                  a_bit, d_bit, s_bit;
  logic                  chk_allowed;
  logic                  do_set, do_clr;

  // Unpack the request
  assign in_kind   = kind_t'(in_tuser[1:0]);
  assign in_proto  = PROTO_W'(in_tuser[2]);
  assign in_pvalid = (32'(in_tuser[2]) < PROTO_COUNT);
  assign in_port   = in_tdata[PORT_BITS-1:0];
  assign in_row    = {in_proto, in_port[PORT_BITS-1:LANE_BITS]};

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Bitmap bits of the held request
  assign a_pos = {lane_r, SEL_ALLOW};
  assign d_pos = {lane_r, SEL_DENY};
  assign s_pos = {lane_r, sel_r};
  assign a_bit = ram_rdata[a_pos];
  assign d_bit = ram_rdata[d_pos];
  assign s_bit = ram_rdata[s_pos];

  // Finish the request once the output slot is free
  assign rmw_go = (st_r == ST_RMW) && (!out_valid_r || out_tready);

  assign chk_allowed = pvalid_r && ((cnt.allow_cnt == '0) || a_bit) &&
                       ((cnt.deny_cnt == '0) || !d_bit);
  assign do_set = rmw_go && pvalid_r && (kind_r == KIND_ADD) && !s_bit;
  assign do_clr = rmw_go && pvalid_r && (kind_r == KIND_DEL) && s_bit;

  // Count updates
  assign upd.inc   = do_set;
  assign upd.dec   = do_clr;
  assign upd.proto = proto_r;
  assign upd.sel   = sel_r;

  // Bitmap write: zero rows while clearing, flip one bit on a change
  always_comb begin
    if (st_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = do_set || do_clr;
      ram_waddr = row_r;
      ram_wdata = ram_rdata ^ (ROW_W'(1) << s_pos);
    end
  end

  // Next state
  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    unique case (st_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ROW_ADDR_W'(RAM_DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_go) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  // Output valid: load on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (rmw_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_kind;
      proto_r  <= in_proto;
      pvalid_r <= in_pvalid;
      sel_r    <= in_tuser[3];
      lane_r   <= in_port[LANE_BITS-1:0];
      row_r    <= in_row;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (rmw_go) begin
      out_allowed_r <= (kind_r == KIND_CHECK) && chk_allowed;
      out_present_r <= pvalid_r && ((kind_r == KIND_ADD) || (kind_r == KIND_DEL)) && s_bit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_allowed_r};
  assign out_tuser  = out_present_r;

  pafilt_bitmap_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc && in_pvalid),
    .raddr (in_row),
    .rdata (ram_rdata)
  );

  pafilt_set_counts u_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_proto (proto_r),
    .rd_cnt   (cnt),
    .upd      (upd)
  );

  // Checks
  `PAFILT_ASSERT_NOW(a_no_take_clr, st_r == ST_CLEAR, !in_tready, "request taken during clear")
  `PAFILT_ASSERT_NEXT(a_take_rmw, in_acc, st_r == ST_RMW, "accepted request not processed")
  `PAFILT_ASSERT_NOW(a_we_idle, st_r == ST_IDLE, !ram_we, "bitmap written while idle")
  `PAFILT_ASSERT_NEXT(a_rmw_out, rmw_go, out_valid_r, "finished request gave no result")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for port_allow_deny_filter_core: streams check/add/delete
// requests, predicts every verdict from a private copy of the port sets.
// Depends on pafilt_pkg and the port_allow_deny_filter_core RTL.
`timescale 1ns / 1ps
module tb_top;
  import pafilt_pkg::*;

  localparam int RAND_TARGET = 650;
  localparam int POOL_SIZE   = 12;
  localparam int SET_IDS     = PROTO_COUNT * 2;

  // One filter request and the verdict it should produce
  typedef struct {
    kind_t                   kind;
    logic                    proto;
    logic                    sel;
    logic [PORT_FIELD_W-1:0] port;
    bit                      drain_first;
  } filt_req_t;

  typedef struct {
    logic allowed;
    logic was_present;
  } verdict_t;

  // Receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;

  port_allow_deny_filter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Shadow copy of the port sets: membership bit per {protocol, set, port}
  bit             member_map [0:(SET_IDS << PORT_BITS) - 1];
  bit [CNT_W-1:0] member_cnt [0:SET_IDS-1];

  filt_req_t req_queue[$];
  verdict_t  verdict_queue[$];
  logic [PORT_FIELD_W-1:0] port_pool [0:POOL_SIZE-1];
  int        accepted_cnt = 0;
  int        total_reqs   = 0;
  int        error_count  = 0;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Apply one request to the shadow sets and return its verdict
  function automatic verdict_t lookup_and_update(filt_req_t r);
    verdict_t               v;
    logic [1:0]             set_id;
    logic [1:0]             allow_id;
    logic [1:0]             deny_id;
    logic [PORT_BITS-1:0]   key;
    logic [PORT_BITS+1:0]   idx;
    logic                   hit;
    logic                   ok_allow;
    logic                   ok_deny;
    v.allowed     = 1'b0;
    v.was_present = 1'b0;
    key      = r.port[PORT_BITS-1:0];
    allow_id = {r.proto, SEL_ALLOW};
    deny_id  = {r.proto, SEL_DENY};
    set_id   = {r.proto, r.sel};
    if (int'(r.proto) < PROTO_COUNT) begin
      case (r.kind)
        KIND_CHECK: begin
          ok_allow  = (member_cnt[allow_id] == 0) || member_map[{allow_id, key}];
          ok_deny   = (member_cnt[deny_id] == 0) || !member_map[{deny_id, key}];
          v.allowed = ok_allow && ok_deny;
        end
        KIND_ADD, KIND_DEL: begin
          idx           = {set_id, key};
          hit           = member_map[idx];
          v.was_present = hit;
          if (r.kind == KIND_ADD && !hit) begin
            member_map[idx]    = 1'b1;
            member_cnt[set_id] = member_cnt[set_id] + 1'b1;
          end else if (r.kind == KIND_DEL && hit) begin
            member_map[idx]    = 1'b0;
            member_cnt[set_id] = member_cnt[set_id] - 1'b1;
          end
        end
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic push_req(input kind_t k, input logic p, input logic s,
                          input logic [PORT_FIELD_W-1:0] port, input bit drain);
    filt_req_t r;
    r.kind        = k;
    r.proto       = p;
    r.sel         = s;
    r.port        = port;
    r.drain_first = drain;
    req_queue.push_back(r);
    total_reqs++;
  endtask

  // Mostly pool ports so sets fill and get hit; sometimes any port
  function automatic logic [PORT_FIELD_W-1:0] pick_port();
    if ($urandom_range(0, 3) != 0)
      return port_pool[$urandom_range(0, POOL_SIZE - 1)];
    return PORT_FIELD_W'($urandom_range(0, 65535));
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_CHECK;
    if (r < 72) return KIND_ADD;
    if (r < 95) return KIND_DEL;
    return KIND_NOP;
  endfunction

  // Driver: bursts of requests separated by random gaps
  int        burst_left = 0;
  int        gap_left   = 0;
  filt_req_t cur_req;

  always @(posedge clk) begin
    logic v_next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      v_next = in_tvalid;
      // record the verdict of a taken request
      if (in_tvalid && in_tready) begin
        verdict_queue.push_back(lookup_and_update(cur_req));
        accepted_cnt++;
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_queue.size() > 0 &&
                     !(req_queue[0].drain_first && verdict_queue.size() != 0)) begin
          cur_req  = req_queue.pop_front();
          v_next   = 1'b1;
          in_tdata <= cur_req.port;
          in_tuser <= {cur_req.sel, cur_req.proto, cur_req.kind};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_tvalid <= v_next;
    end
  end

  // Receiver: switch among stall patterns every so often
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       rx_span_left = 0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_span_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_span_left = $urandom_range(20, 200);
      end else begin
        rx_span_left--;
      end
      case (rx_mode)
        RX_ALWAYS: rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
        default:   rdy = ($urandom_range(0, 7) != 0);
      endcase
      out_tready <= rdy;
    end
  end

  // Monitor: compare each verdict with the oldest prediction
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_queue.size() == 0) begin
        report("verdict with no request pending");
      end else begin
        exp_v = verdict_queue.pop_front();
        if (out_tdata[0] !== exp_v.allowed)
          report($sformatf("allowed got %b want %b", out_tdata[0], exp_v.allowed));
        if (out_tuser[0] !== exp_v.was_present)
          report($sformatf("was_present got %b want %b", out_tuser[0], exp_v.was_present));
        if (out_tdata[7:1] !== 7'd0)
          report($sformatf("out_tdata pad bits got %b", out_tdata[7:1]));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  chunk;
    int  i;
    logic fp;
    logic fs;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'h8000;
    port_pool[3] = 16'h0001;
    for (i = 4; i < POOL_SIZE; i++)
      port_pool[i] = PORT_FIELD_W'($urandom_range(0, 65535));

    // directed: empty sets, duplicates, allow/deny interplay, sets emptied again
    push_req(KIND_CHECK, 1'b0, SEL_ALLOW, 16'h0000, 1'b0);
    push_req(KIND_NOP,   1'b0, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_ADD,   1'b0, SEL_ALLOW, 16'h0000, 1'b0);
    push_req(KIND_ADD,   1'b0, SEL_ALLOW, 16'h0000, 1'b0);
    push_req(KIND_CHECK, 1'b0, SEL_ALLOW, 16'h0000, 1'b0);
    push_req(KIND_CHECK, 1'b0, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_ADD,   1'b0, SEL_DENY,  16'hFFFF, 1'b0);
    push_req(KIND_CHECK, 1'b0, SEL_DENY,  16'hFFFF, 1'b0);
    push_req(KIND_ADD,   1'b0, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_CHECK, 1'b0, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_CHECK, 1'b1, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_ADD,   1'b1, SEL_DENY,  16'h8000, 1'b0);
    push_req(KIND_CHECK, 1'b1, SEL_ALLOW, 16'h8000, 1'b0);
    push_req(KIND_CHECK, 1'b1, SEL_DENY,  16'h7FFF, 1'b0);
    push_req(KIND_DEL,   1'b1, SEL_DENY,  16'h7FFF, 1'b0);
    push_req(KIND_DEL,   1'b1, SEL_DENY,  16'h8000, 1'b0);
    push_req(KIND_CHECK, 1'b1, SEL_ALLOW, 16'h8000, 1'b0);
    push_req(KIND_DEL,   1'b0, SEL_ALLOW, 16'h0000, 1'b0);
    push_req(KIND_DEL,   1'b0, SEL_ALLOW, 16'hFFFF, 1'b0);
    push_req(KIND_DEL,   1'b0, SEL_DENY,  16'hFFFF, 1'b0);
    push_req(KIND_CHECK, 1'b0, SEL_DENY,  16'h1234, 1'b0);
    push_req(KIND_NOP,   1'b1, SEL_DENY,  16'h5A5A, 1'b0);

    // random: chunks of mixed requests; after every odd chunk, delete all pool ports from one set and probe it
    chunk = 0;
    while (total_reqs < RAND_TARGET) begin
      for (i = 0; i < 40; i++)
        push_req(pick_kind(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 pick_port(), (i == 0 && (chunk == 0 || chunk == 6)));
      if (chunk % 2 == 1) begin
        fp = 1'($urandom_range(0, 1));
        fs = 1'($urandom_range(0, 1));
        for (i = 0; i < POOL_SIZE; i++)
          push_req(KIND_DEL, fp, fs, port_pool[i], 1'b0);
        for (i = 0; i < 3; i++)
          push_req(KIND_CHECK, fp, 1'($urandom_range(0, 1)), pick_port(), 1'b0);
      end
      chunk++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // hold until every request is taken and every verdict has come
    while (accepted_cnt != total_reqs) @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("port_allow_deny_filter_core test passed");
    end else begin
      $display("port_allow_deny_filter_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("port_allow_deny_filter_core test failed");
    $finish;
  end

endmodule
